// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk while rst is low.
`define CGPS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond implies expr on the same edge.
`define CGPS_ASSERT_IMPL(lbl, clk, rst, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

`endif

// ----- hw/rtl/cgps_pkg.sv -----
// ----------------------------------------------------------------------------
// cgps_pkg
// Types and constants for the current gated pulse sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cgps_pkg;

  localparam int CFG_W = 16;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] REG_PULSE_LEN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_COOLDOWN_LEN = 2'd1;

  localparam logic [CFG_W-1:0] PULSE_LEN_RST    = 16'd200;
  localparam logic [CFG_W-1:0] COOLDOWN_LEN_RST = 16'd2000;

  localparam logic [2:0] PH_ARM      = 3'd0;
  localparam logic [2:0] PH_WAIT_EN  = 3'd1;
  localparam logic [2:0] PH_WAIT_CUR = 3'd2;
  localparam logic [2:0] PH_PULSE    = 3'd3;
  localparam logic [2:0] PH_COOL     = 3'd4;
  localparam logic [2:0] PH_WAIT_LOW = 3'd5;
  localparam logic [2:0] PH_FAULT    = 3'd6;

  typedef enum logic [6:0] {
    ST_ARM      = 7'b0000001,
    ST_WAIT_EN  = 7'b0000010,
    ST_WAIT_CUR = 7'b0000100,
    ST_PULSE    = 7'b0001000,
    ST_COOL     = 7'b0010000,
    ST_WAIT_LOW = 7'b0100000,
    ST_FAULT    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic       gate_on;
    logic       fault_latched;
    logic [2:0] phase;
  } result_t;

  function automatic logic [2:0] phase_code(input state_t st);
    logic [2:0] code;
    unique case (st)
      ST_ARM:      code = PH_ARM;
      ST_WAIT_EN:  code = PH_WAIT_EN;
      ST_WAIT_CUR: code = PH_WAIT_CUR;
      ST_PULSE:    code = PH_PULSE;
      ST_COOL:     code = PH_COOL;
      ST_WAIT_LOW: code = PH_WAIT_LOW;
      default:     code = PH_FAULT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cgps_seq.sv -----
// ----------------------------------------------------------------------------
// cgps_seq
// Sequencer state, elapsed counter and next-state logic, one step per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_seq #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire logic                      enable_level,
  input  wire logic                      current_seen,
  input  wire logic [cgps_pkg::CFG_W-1:0] pulse_len,
  input  wire logic [cgps_pkg::CFG_W-1:0] cooldown_len,
  output cgps_pkg::result_t              result_next
);

  localparam int CMP_W = (COUNT_WIDTH > cgps_pkg::CFG_W) ? COUNT_WIDTH : cgps_pkg::CFG_W;

  cgps_pkg::state_t       state, state_next;
  logic [COUNT_WIDTH-1:0] elapsed, elapsed_next;
  logic                   gate, gate_next;
  logic [COUNT_WIDTH-1:0] elapsed_inc;
  logic [CMP_W-1:0]       inc_x;

  // saturating count
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + COUNT_WIDTH'(1);
  assign inc_x       = CMP_W'(elapsed_inc);

  always_comb begin
    state_next   = state;
    elapsed_next = elapsed;
    gate_next    = gate;
    unique case (state)
      cgps_pkg::ST_ARM: begin
        if (current_seen) begin
          gate_next  = 1'b0;
          state_next = cgps_pkg::ST_FAULT;
        end else if (enable_level) begin
          gate_next  = 1'b1;
          state_next = cgps_pkg::ST_WAIT_CUR;
        end else begin
          state_next = cgps_pkg::ST_WAIT_EN;
        end
      end
      cgps_pkg::ST_WAIT_EN: begin
        if (enable_level) begin
          gate_next  = 1'b1;
          state_next = cgps_pkg::ST_WAIT_CUR;
        end
      end
      cgps_pkg::ST_WAIT_CUR: begin
        if (current_seen) begin
          elapsed_next = '0;
          state_next   = cgps_pkg::ST_PULSE;
        end else if (!enable_level) begin
          gate_next  = 1'b0;
          state_next = cgps_pkg::ST_WAIT_LOW;
        end
      end
      cgps_pkg::ST_PULSE: begin
        elapsed_next = elapsed_inc;
        if (inc_x >= CMP_W'(pulse_len) || !enable_level) begin
          gate_next  = 1'b0;
          state_next = cgps_pkg::ST_COOL;
        end
      end
      cgps_pkg::ST_COOL: begin
        elapsed_next = elapsed_inc;
        if (inc_x >= CMP_W'(cooldown_len)) begin
          state_next = cgps_pkg::ST_WAIT_LOW;
        end
      end
      cgps_pkg::ST_WAIT_LOW: begin
        if (!enable_level) begin
          state_next = cgps_pkg::ST_ARM;
        end
      end
      default: begin
        gate_next  = 1'b0;
        state_next = cgps_pkg::ST_FAULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cgps_pkg::ST_ARM;
      elapsed <= '0;
      gate    <= 1'b0;
    end else if (step) begin
      state   <= state_next;
      elapsed <= elapsed_next;
      gate    <= gate_next;
    end
  end

  assign result_next.gate_on       = gate_next;
  assign result_next.fault_latched = (state_next == cgps_pkg::ST_FAULT);
  assign result_next.phase         = cgps_pkg::phase_code(state_next);

endmodule

`default_nettype wire

// ----- hw/rtl/cgps_obuf.sv -----
// ----------------------------------------------------------------------------
// cgps_obuf
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module cgps_obuf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cgps_pkg::result_t result_next,
  output logic                   load,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cgps_pkg::result_t      result
);

  logic out_valid_next;

  assign in_stall       = out_valid & out_stall;
  assign load           = in_valid & ~in_stall;
  assign out_valid_next = load | (out_valid & out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/current_gated_pulse_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// current_gated_pulse_sequencer_core
// Timing: the result of an accepted input beat is registered and valid in the next cycle.
// Throughput: one beat per cycle; input stalls only while a result is held.
// Reset: synchronous; phase arm, counter zero, gate off, no result pending,
// pulse_len 200, cooldown_len 2000.
// ----------------------------------------------------------------------------
`default_nettype none

module current_gated_pulse_sequencer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write_en,
  input  wire logic [cgps_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [cgps_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       enable_level,
  input  wire logic                       current_seen,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            gate_on,
  output logic                            fault_latched,
  output logic [2:0]                      phase
);

  logic [cgps_pkg::CFG_W-1:0] pulse_len;
  logic [cgps_pkg::CFG_W-1:0] cooldown_len;
  logic                       load;
  cgps_pkg::result_t          result_next;
  cgps_pkg::result_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_len    <= cgps_pkg::PULSE_LEN_RST;
      cooldown_len <= cgps_pkg::COOLDOWN_LEN_RST;
    end else if (cfg_write_en) begin
      if (cfg_index == cgps_pkg::REG_PULSE_LEN) begin
        pulse_len <= cfg_data;
      end
      if (cfg_index == cgps_pkg::REG_COOLDOWN_LEN) begin
        cooldown_len <= cfg_data;
      end
    end
  end

  cgps_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (load),
    .enable_level (enable_level),
    .current_seen (current_seen),
    .pulse_len    (pulse_len),
    .cooldown_len (cooldown_len),
    .result_next  (result_next)
  );

  cgps_obuf u_obuf (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .result_next (result_next),
    .load        (load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign gate_on       = result.gate_on;
  assign fault_latched = result.fault_latched;
  assign phase         = result.phase;

endmodule

`default_nettype wire

// ----- hw/rtl/cgps_checker.sv -----
// ----------------------------------------------------------------------------
// cgps_checker
// Port-level checks for the sequencer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cgps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       gate_on,
  input wire logic       fault_latched,
  input wire logic [2:0] phase
);

  `CGPS_ASSERT_IMPL(a_fault_gate_off, clk, rst, out_valid && fault_latched, !gate_on, "gate on during fault")
  `CGPS_ASSERT_IMPL(a_fault_phase, clk, rst, out_valid, fault_latched == (phase == cgps_pkg::PH_FAULT), "fault flag and phase disagree")
  `CGPS_ASSERT_IMPL(a_gate_phase, clk, rst, out_valid && gate_on, phase == cgps_pkg::PH_WAIT_CUR || phase == cgps_pkg::PH_PULSE, "gate on outside pulse phases")
  `CGPS_ASSERT(a_fault_sticky, clk, rst, out_valid && fault_latched |=> !out_valid || fault_latched, "fault cleared without reset")
  `CGPS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(phase) && $stable(gate_on), "stalled result beat changed")

endmodule

bind current_gated_pulse_sequencer_core cgps_checker u_cgps_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .gate_on       (gate_on),
  .fault_latched (fault_latched),
  .phase         (phase)
);

`default_nettype wire

// ----- dv/cgps_sequencer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgps_sequencer_checker
// Watches the tick and result channels of the pulse sequencer, tracks the
// register writes, predicts gate, fault and phase for every accepted tick
// and compares each result beat with the oldest prediction.
// ----------------------------------------------------------------------------

module cgps_sequencer_checker
  import cgps_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             enable_level,
  input  logic             current_seen,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             gate_on,
  input  logic             fault_latched,
  input  logic [2:0]       phase,
  output int               mismatches,
  output int               pending,
  output int               results_checked,
  output int               pulses_seen
);

  logic [2:0]             seq_phase;
  logic [COUNT_WIDTH-1:0] elapsed_ticks;
  logic                   gate_state;
  logic [CFG_W-1:0]       pulse_len;
  logic [CFG_W-1:0]       cooldown_len;

  result_t expected_results[$];

  initial begin
    mismatches      = 0;
    pending         = 0;
    results_checked = 0;
    pulses_seen     = 0;
  end

  task automatic report_mismatch(input string field, input logic [2:0] got,
                                 input logic [2:0] want);
    $display("ERROR t=%0t result %0d: %s got %0h expected %0h",
             $realtime, results_checked, field, got, want);
    mismatches++;
  endtask

  // One tick of the sequencer; returns the outputs after the tick.
  function automatic result_t advance_sequencer(input logic en, input logic cur);
    result_t r;
    case (seq_phase)
      PH_ARM: begin
        if (cur) begin
          gate_state = 1'b0;
          seq_phase  = PH_FAULT;
        end else if (en) begin
          gate_state = 1'b1;
          seq_phase  = PH_WAIT_CUR;
        end else begin
          seq_phase = PH_WAIT_EN;
        end
      end
      PH_WAIT_EN: begin
        if (en) begin
          gate_state = 1'b1;
          seq_phase  = PH_WAIT_CUR;
        end
      end
      PH_WAIT_CUR: begin
        if (cur) begin
          elapsed_ticks = '0;
          seq_phase     = PH_PULSE;
          pulses_seen++;
        end else if (!en) begin
          gate_state = 1'b0;
          seq_phase  = PH_WAIT_LOW;
        end
      end
      PH_PULSE: begin
        if (~&elapsed_ticks) elapsed_ticks = elapsed_ticks + 1'b1;
        if (elapsed_ticks >= pulse_len || !en) begin
          gate_state = 1'b0;
          seq_phase  = PH_COOL;
        end
      end
      PH_COOL: begin
        if (~&elapsed_ticks) elapsed_ticks = elapsed_ticks + 1'b1;
        if (elapsed_ticks >= cooldown_len) seq_phase = PH_WAIT_LOW;
      end
      PH_WAIT_LOW: begin
        if (!en) seq_phase = PH_ARM;
      end
      default: begin
        gate_state = 1'b0;
        seq_phase  = PH_FAULT;
      end
    endcase
    r.gate_on       = gate_state;
    r.fault_latched = (seq_phase == PH_FAULT);
    r.phase         = seq_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      seq_phase     = PH_ARM;
      elapsed_ticks = '0;
      gate_state    = 1'b0;
      pulse_len     = PULSE_LEN_RST;
      cooldown_len  = COOLDOWN_LEN_RST;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("ERROR t=%0t result beat with no tick outstanding", $realtime);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (gate_on !== want.gate_on)
            report_mismatch("gate_on", {2'b0, gate_on}, {2'b0, want.gate_on});
          if (fault_latched !== want.fault_latched)
            report_mismatch("fault_latched", {2'b0, fault_latched},
                            {2'b0, want.fault_latched});
          if (phase !== want.phase)
            report_mismatch("phase", phase, want.phase);
          results_checked++;
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(advance_sequencer(enable_level, current_seen));
      if (cfg_write_en) begin
        case (cfg_index)
          REG_PULSE_LEN:    pulse_len    = cfg_data;
          REG_COOLDOWN_LEN: cooldown_len = cfg_data;
          default: ;
        endcase
      end
      pending = expected_results.size();
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for current_gated_pulse_sequencer_core. Drives ticks
// as well-formed enable/current pulse sequences plus noise over several
// register settings, a counter saturation run and a final fault; random
// idles on the tick side and stalls on the result side.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CNT_W            = 8;
  localparam int LEN_W            = cgps_pkg::CFG_W;
  localparam int RESET_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int TAIL_CYCLES      = 8;
  localparam int NUM_SETTINGS     = 7;
  localparam int RANDOM_SLOT      = 4;
  localparam int TICKS_PER_SET    = 220;
  localparam int DIRECTED_TICKS   = 21;
  localparam int DIRECTED_REWRITE = 13;
  localparam int MAX_GAP          = 18;
  localparam int SAT_TICKS        = (1 << CNT_W) - 1;

  localparam logic [cgps_pkg::IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [cgps_pkg::IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [LEN_W-1:0]           LEN_MAX     = '1;
  localparam logic [LEN_W-1:0]           CNT_MAX     = LEN_W'(SAT_TICKS);

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       cfg_write_en  = 1'b0;
  logic [cgps_pkg::IDX_W-1:0] cfg_index     = '0;
  logic [LEN_W-1:0]           cfg_data      = '0;
  logic                       in_valid      = 1'b0;
  logic                       enable_level  = 1'b0;
  logic                       current_seen  = 1'b0;
  logic                       out_stall     = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic                       gate_on;
  logic                       fault_latched;
  logic [2:0]                 phase;

  int mismatches;
  int pending;
  int results_checked;
  int pulses_seen;

  // stimulus shaping
  bit quiet         = 1'b0;
  bit in_idle_mode  = 1'b1;
  bit out_idle_mode = 1'b1;
  bit arm_guard     = 1'b1;
  bit last_en       = 1'b0;
  int ticks_sent    = 0;
  int out_wait      = 0;
  int idle_cycles   = 0;

  // en in bit 1, current in bit 0
  bit [1:0] directed_ticks[DIRECTED_TICKS] = '{
    2'b00, 2'b00, 2'b10, 2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b11, 2'b11,
    2'b01, 2'b00, 2'b10, 2'b10, 2'b00, 2'b10, 2'b11, 2'b11, 2'b10, 2'b00,
    2'b00};

  int pulse_set[NUM_SETTINGS]    = '{0, 2, 7, 12, 0, 20, 1};
  int cooldown_set[NUM_SETTINGS] = '{0, 5, 3, 40, 0, 20, 0};

  always #2 clk = ~clk;

  current_gated_pulse_sequencer_core #(
    .COUNT_WIDTH (CNT_W)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .enable_level  (enable_level),
    .current_seen  (current_seen),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .gate_on       (gate_on),
    .fault_latched (fault_latched),
    .phase         (phase)
  );

  cgps_sequencer_checker #(
    .COUNT_WIDTH (CNT_W)
  ) i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .enable_level    (enable_level),
    .current_seen    (current_seen),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gate_on         (gate_on),
    .fault_latched   (fault_latched),
    .phase           (phase),
    .mismatches      (mismatches),
    .pending         (pending),
    .results_checked (results_checked),
    .pulses_seen     (pulses_seen)
  );

  function automatic int draw_gap(input bit side_idles);
    if (quiet || !side_idles) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // result side: stall for a drawn number of cycles after every beat
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_stall <= 1'b0;
      out_wait  <= 0;
    end else if (out_valid && !out_stall) begin
      gap = draw_gap(out_idle_mode);
      out_wait  <= gap;
      out_stall <= (gap != 0);
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait  <= 0;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("current_gated_pulse_sequencer_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Current is only raised after an enable-high tick, so the arm check
  // never sees it unless the fault is wanted.
  task automatic send_tick(input bit en, input bit cur);
    int gap;
    gap = draw_gap(in_idle_mode);
    if (arm_guard && !last_en) cur = 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    enable_level <= en;
    current_seen <= cur;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_en = en;
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cgps_pkg::IDX_W-1:0] idx,
                           input logic [LEN_W-1:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // any state but fault ends in wait enable after four low ticks with zero lengths
  task automatic settle_to_wait_enable();
    wait_idle();
    write_reg(cgps_pkg::REG_PULSE_LEN, '0);
    write_reg(cgps_pkg::REG_COOLDOWN_LEN, '0);
    repeat (4) send_tick(1'b0, 1'b0);
  endtask

  task automatic pulse_burst(input int pl, input int cl);
    repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
    repeat ($urandom_range(0, 4)) send_tick(1'b1, 1'b0);
    if ($urandom_range(0, 5) == 0) begin
      // enable drops before current rises
      repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
    end else begin
      send_tick(1'b1, 1'b1);
      repeat ($urandom_range(0, pl + 3))
        send_tick($urandom_range(0, 7) != 0, coin());
      repeat ($urandom_range(0, cl + 3))
        send_tick(coin(), coin());
      repeat ($urandom_range(1, 3)) send_tick(1'b0, 1'b0);
    end
  endtask

  initial begin
    int pl;
    int cl;
    int target;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk through the phases, first at reset lengths
    for (int i = 0; i < DIRECTED_TICKS; i++) begin
      if (i == DIRECTED_REWRITE) begin
        wait_idle();
        write_reg(cgps_pkg::REG_PULSE_LEN, '0);
        write_reg(cgps_pkg::REG_COOLDOWN_LEN, '0);
        write_reg(REG_SPARE_A, LEN_MAX);
        write_reg(REG_SPARE_B, 16'h5a5a);
      end
      send_tick(directed_ticks[i][1], directed_ticks[i][0]);
    end

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_idle();
      pl = pulse_set[s];
      cl = cooldown_set[s];
      if (s == RANDOM_SLOT) begin
        pl = $urandom_range(0, 15);
        cl = $urandom_range(0, 60);
      end
      write_reg(cgps_pkg::REG_PULSE_LEN, LEN_W'(pl));
      write_reg(cgps_pkg::REG_COOLDOWN_LEN, LEN_W'(cl));
      in_idle_mode  = ($urandom_range(0, 3) != 0);
      out_idle_mode = ($urandom_range(0, 3) != 0);
      target = ticks_sent + TICKS_PER_SET;
      while (ticks_sent < target) begin
        if ($urandom_range(0, 4) != 0) begin
          pulse_burst(pl, cl);
        end else begin
          repeat ($urandom_range(1, 8))
            send_tick(coin(), coin());
        end
      end
    end

    // counter saturation: full-length pulse, then cooldown must end
    settle_to_wait_enable();
    send_tick(1'b1, 1'b0);
    wait_idle();
    write_reg(cgps_pkg::REG_PULSE_LEN, CNT_MAX);
    write_reg(cgps_pkg::REG_COOLDOWN_LEN, CNT_MAX);
    quiet = 1'b1;
    send_tick(1'b1, 1'b1);
    repeat (SAT_TICKS) send_tick(1'b1, coin());
    repeat (3) send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b0);
    quiet = 1'b0;

    // current seen at the arm check latches the fault for good
    settle_to_wait_enable();
    in_idle_mode  = 1'b1;
    out_idle_mode = 1'b1;
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    arm_guard = 1'b0;
    send_tick(1'b0, 1'b1);
    repeat (20) send_tick(coin(), coin());

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d ticks and %0d result beats over %0d length settings,",
             ticks_sent, results_checked, NUM_SETTINGS + 3);
    $display("  %0d gate pulses, a saturated count and a latched fault; %0d mismatches",
             pulses_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("current_gated_pulse_sequencer_core test passed");
    end else begin
      $display("current_gated_pulse_sequencer_core test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/cgps_pkg.sv
hw/rtl/cgps_seq.sv
hw/rtl/cgps_obuf.sv
hw/rtl/current_gated_pulse_sequencer_core.sv
hw/rtl/cgps_checker.sv
dv/cgps_sequencer_checker.sv
dv/tb_top.sv
